// File: design/fss_pkg.sv
// Package for the fraction set statistics unit.
// Holds the transaction payload types, status struct and sequencer states.
// No dependencies.
package fss_pkg;

    localparam int VAL_W   = 16;
    localparam int COUNT_W = 16;
    localparam int SUM_W   = 32;

    typedef struct packed {
        logic [VAL_W-1:0] numerator;
        logic [VAL_W-1:0] denominator;
        logic             last_item;
    } fss_item_t;

    typedef struct packed {
        logic [VAL_W-1:0]   min_numerator;
        logic [VAL_W-1:0]   min_denominator;
        logic [COUNT_W-1:0] irreducible_count;
        logic [SUM_W-1:0]   reduced_numerator_sum;
    } fss_result_t;

    // Status of the gcd / divide engine toward the control sequencer
    typedef struct packed {
        logic             busy;
        logic             coprime;
        logic [VAL_W-1:0] quotient;
    } gcd_stat_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_MUL_L,
        T_MUL_R,
        T_WAIT,
        T_UPDATE
    } top_state_t;

    typedef enum logic [2:0] {
        G_IDLE,
        G_STRIP,
        G_ODD,
        G_LOOP,
        G_DIV
    } gcd_state_t;

endpackage

// File: design/fss_stream_if.sv
// Valid/ready stream interface used for the item and result channels.
// Payload type is a parameter; types come from fss_pkg.
interface fss_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// File: design/fss_gcd.sv
// Iterative gcd and divide engine: binary gcd, then restoring division of the
// numerator by the gcd. One shared subtractor does all compare and subtract work.
// Depends on fss_pkg.
module fss_gcd #(
    parameter int EW = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [EW-1:0]       num,
    input  logic [EW-1:0]       den,
    output fss_pkg::gcd_stat_t  stat
);

    localparam int CW = $clog2(EW);
    localparam int VW = fss_pkg::VAL_W;

    fss_pkg::gcd_state_t state_reg, state_next;
    logic [EW-1:0] a_reg, a_next;
    logic [EW-1:0] b_reg, b_next;
    logic [EW-1:0] q_reg, q_next;
    logic [EW-1:0] r_reg, r_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          cop_reg, cop_next;

    // shared subtractor
    logic [EW:0]   sub_x;
    logic [EW:0]   sub_y;
    logic [EW+1:0] diff;
    logic          borrow;

    assign diff   = {1'b0, sub_x} - {1'b0, sub_y};
    assign borrow = diff[EW+1];

    always_comb
    begin
        sub_x = {1'b0, b_reg};
        sub_y = {1'b0, a_reg};
        if (state_reg == fss_pkg::G_DIV)
        begin
            sub_x = {r_reg, q_reg[EW-1]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        cop_next   = cop_reg;
        unique case (state_reg)
            fss_pkg::G_IDLE:
            begin
                if (start)
                begin
                    a_next   = num;
                    b_next   = den;
                    q_next   = num;
                    r_next   = '0;
                    k_next   = '0;
                    cnt_next = '0;
                    if (num == '0 && den == '0)
                    begin
                        // gcd is zero: nothing counted, nothing summed
                        q_next   = '0;
                        cop_next = 1'b0;
                    end
                    else if (num == '0 || den == '0)
                    begin
                        // gcd of a value and zero is the value itself
                        a_next     = num | den;
                        cop_next   = ((num | den) == EW'(1));
                        state_next = fss_pkg::G_DIV;
                    end
                    else
                    begin
                        state_next = fss_pkg::G_STRIP;
                    end
                end
            end
            fss_pkg::G_STRIP:
            begin
                // drop common factors of two
                if (a_reg[0] || b_reg[0])
                begin
                    state_next = fss_pkg::G_ODD;
                end
                else
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + CW'(1);
                end
            end
            fss_pkg::G_ODD:
            begin
                if (a_reg[0])
                begin
                    state_next = fss_pkg::G_LOOP;
                end
                else
                begin
                    a_next = a_reg >> 1;
                end
            end
            fss_pkg::G_LOOP:
            begin
                if (b_reg == '0)
                begin
                    a_next     = a_reg << k_reg;
                    cop_next   = (k_reg == '0) && (a_reg == EW'(1));
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = fss_pkg::G_DIV;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (borrow)
                begin
                    // keep a as the smaller odd value
                    a_next = b_reg;
                    b_next = a_reg;
                end
                else
                begin
                    b_next = diff[EW-1:0];
                end
            end
            fss_pkg::G_DIV:
            begin
                q_next   = {q_reg[EW-2:0], ~borrow};
                r_next   = borrow ? sub_x[EW-1:0] : diff[EW-1:0];
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(EW-1))
                begin
                    state_next = fss_pkg::G_IDLE;
                end
            end
            default:
            begin
                state_next = fss_pkg::G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fss_pkg::G_IDLE;
            cop_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cop_reg   <= cop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy     = (state_reg != fss_pkg::G_IDLE);
    assign stat.coprime  = cop_reg;
    assign stat.quotient = VW'(q_reg);

endmodule

// File: design/fraction_set_statistics_unit.sv
// Fraction set statistics unit: running minimum fraction, coprime count and
// reduced numerator sum over a set, one result per set on the last item.
// An accepted item passes through T_MUL_L, T_MUL_R, T_WAIT (until the gcd/divide
// engine with its one subtractor is done) and T_UPDATE; a new item is taken only
// when the block is back in T_IDLE, and a last item waits while a result is held.
// Reset: asynchronous, active low; clears the set state and the result valid.
module fraction_set_statistics_unit #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    fss_stream_if.sink   item,
    fss_stream_if.source result
);

    localparam int VW = fss_pkg::VAL_W;
    localparam int CNW = fss_pkg::COUNT_W;
    localparam int SW = fss_pkg::SUM_W;
    localparam int EW = (VALUE_WIDTH < VW) ? VALUE_WIDTH : VW;

    fss_pkg::top_state_t state_reg, state_next;

    logic [EW-1:0]     n_reg, d_reg;
    logic              last_reg;
    logic [2*EW-1:0]   lhs_reg, lhs_next;
    logic [2*EW-1:0]   rhs_reg, rhs_next;
    logic [EW-1:0]     bn_reg, bn_next;
    logic [EW-1:0]     bd_reg, bd_next;
    logic              seen_reg, seen_next;
    logic [CNW-1:0]    tally_reg, tally_next;
    logic [SW-1:0]     total_reg, total_next;
    fss_pkg::fss_result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic [EW-1:0]     mul_a, mul_b;
    logic [2*EW-1:0]   prod;
    fss_pkg::gcd_stat_t gstat;

    // update values
    logic              better;
    logic [EW-1:0]     bn_upd, bd_upd;
    logic [CNW-1:0]    tally_upd;
    logic [SW:0]       sum_wide;
    logic [SW-1:0]     total_upd;

    assign accept     = item.valid && item.ready;
    assign item.ready = (state_reg == fss_pkg::T_IDLE);

    fss_gcd #(
        .EW (EW)
    ) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == fss_pkg::T_MUL_L),
        .num   (n_reg),
        .den   (d_reg),
        .stat  (gstat)
    );

    // one multiplier, used for both cross-products
    assign mul_a = (state_reg == fss_pkg::T_MUL_L) ? n_reg : bn_reg;
    assign mul_b = (state_reg == fss_pkg::T_MUL_L) ? bd_reg : d_reg;
    assign prod  = (2*EW)'(mul_a) * (2*EW)'(mul_b);

    always_comb
    begin
        better = !seen_reg || (lhs_reg < rhs_reg) ||
                 ((lhs_reg == rhs_reg) && (d_reg < bd_reg));
        bn_upd = better ? n_reg : bn_reg;
        bd_upd = better ? d_reg : bd_reg;
        tally_upd = tally_reg;
        if (gstat.coprime && (tally_reg != '1))
        begin
            tally_upd = tally_reg + CNW'(1);
        end
        sum_wide  = {1'b0, total_reg} + (SW+1)'(gstat.quotient);
        total_upd = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        seen_next      = seen_reg;
        tally_next     = tally_reg;
        total_next     = total_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        unique case (state_reg)
            fss_pkg::T_IDLE:
            begin
                if (accept)
                begin
                    state_next = fss_pkg::T_MUL_L;
                end
            end
            fss_pkg::T_MUL_L:
            begin
                lhs_next   = prod;
                state_next = fss_pkg::T_MUL_R;
            end
            fss_pkg::T_MUL_R:
            begin
                rhs_next   = prod;
                state_next = fss_pkg::T_WAIT;
            end
            fss_pkg::T_WAIT:
            begin
                if (!gstat.busy)
                begin
                    state_next = fss_pkg::T_UPDATE;
                end
            end
            fss_pkg::T_UPDATE:
            begin
                if (!last_reg)
                begin
                    bn_next    = bn_upd;
                    bd_next    = bd_upd;
                    seen_next  = 1'b1;
                    tally_next = tally_upd;
                    total_next = total_upd;
                    state_next = fss_pkg::T_IDLE;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    // emit the set result and clear for the next set
                    out_next.min_numerator         = VW'(bn_upd);
                    out_next.min_denominator       = VW'(bd_upd);
                    out_next.irreducible_count     = tally_upd;
                    out_next.reduced_numerator_sum = total_upd;
                    out_valid_next = 1'b1;
                    bn_next    = '0;
                    bd_next    = EW'(1);
                    seen_next  = 1'b0;
                    tally_next = '0;
                    total_next = '0;
                    state_next = fss_pkg::T_IDLE;
                end
            end
            default:
            begin
                state_next = fss_pkg::T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fss_pkg::T_IDLE;
            bn_reg        <= '0;
            bd_reg        <= EW'(1);
            seen_reg      <= 1'b0;
            tally_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bn_reg        <= bn_next;
            bd_reg        <= bd_next;
            seen_reg      <= seen_next;
            tally_reg     <= tally_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg    <= item.data.numerator[EW-1:0];
            d_reg    <= item.data.denominator[EW-1:0];
            last_reg <= item.data.last_item;
        end
        lhs_reg <= lhs_next;
        rhs_reg <= rhs_next;
        out_reg <= out_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

`ifndef SYNTH
    // a new result only appears after the last item of a set was processed
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(last_reg))
        else $error("result raised without a last item");

    // the engine never runs while the block is waiting for an item
    a_engine_idle: assert property (@(posedge clk) disable iff (!rst_n)
        gstat.busy |-> (state_reg != fss_pkg::T_IDLE))
        else $error("gcd engine busy while block idle");

    // a committed non-last item leaves the set marked as started
    a_seen_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fss_pkg::T_UPDATE) && !last_reg |=> seen_reg)
        else $error("set not marked started after update");
`endif

endmodule
